@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the persistence qualifier table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PQT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");
`define PQT_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define PQT_ASSERT(lbl, clk_s, rst_s, prop)
`define PQT_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

@@ design/pqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Persistence qualifier table package
// Widths, register codes, item types and controller/datapath structs.
// ----------------------------------------------------------------------------
package pqt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SCAN_DEPTH_DEF  = 128;

  localparam int ADDR_W = 48;
  localparam int SWAP_W = 32;
  localparam int HITS_W = 8;
  localparam int CFG_W  = 7;
  localparam int DROP_W = 16;
  localparam int SEEN_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

  localparam logic REG_MIN_OBS  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [CFG_W-1:0] MIN_OBS_RST  = 7'd3;
  localparam logic [CFG_W-1:0] CAPACITY_RST = 7'd64;

  localparam logic OP_CAND = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_end;
    logic [SWAP_W-1:0] swap_kb;
  } pqt_in_t;

  typedef struct packed {
    logic              has_region;
    logic [ADDR_W-1:0] stable_start;
    logic [ADDR_W-1:0] stable_end;
    logic [SWAP_W-1:0] stable_swap_kb;
    logic [HITS_W-1:0] observations;
    logic [SEEN_W-1:0] candidates_seen;
    logic [DROP_W-1:0] dropped_count;
    logic              last;
  } pqt_out_t;

  typedef struct packed {
    logic cap_in;
    logic drop;
    logic append;
    logic clr_i;
    logic inc_i;
    logic clr_j;
    logic inc_j;
    logic load_cur;
    logic set_h;
    logic wr_hits;
    logic clr_ahead;
    logic load_rank;
    logic rank_step;
    logic wr_keep;
    logic clr_copy;
    logic copy_step;
    logic commit_tracked;
    logic emit;
    logic emit_none;
    logic finish;
    logic sc_use_j;
    logic tr_use_i;
  } pqt_cmd_t;

  typedef struct packed {
    logic scan_full;
    logic i_eq_scan;
    logic j_eq_scan;
    logic i_eq_tr;
    logic j_eq_tr;
    logic dup_hit;
    logic start_match;
    logic full_match;
    logic is_qual;
    logic none_qual;
    logic out_free;
  } pqt_status_t;

endpackage

@@ design/pqt_channels.sv @@
// ----------------------------------------------------------------------------
// Persistence qualifier table channels
// Valid/ready interfaces for the candidate and result streams.
// ----------------------------------------------------------------------------
interface pqt_cand_if import pqt_pkg::*; ();
  logic    valid;
  logic    ready;
  pqt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pqt_result_if import pqt_pkg::*; ();
  logic     valid;
  logic     ready;
  pqt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/persistence_qualifier_table.sv @@
// ----------------------------------------------------------------------------
// Persistence qualifier table
// Tracks candidate regions across scans and reports those that stay stable.
// A candidate on a full scan buffer is dropped; else it is checked against those held.
// End of scan updates hits, ranks, rebuilds the table and emits results, stalling on
// result back-pressure.
// One item at a time; the next item is taken once the block is back in idle.
// Synchronous reset empties the table and scan buffer counters and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module persistence_qualifier_table import pqt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SCAN_DEPTH  = SCAN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  pqt_cand_if.sink           cand,
  pqt_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] min_obs;
  logic [CFG_W-1:0] capacity;
  logic             reg_sel;
  pqt_cmd_t         cmd;
  pqt_status_t      status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_obs  <= MIN_OBS_RST;
      capacity <= CAPACITY_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_MIN_OBS:  min_obs  <= pwdata[CFG_W-1:0];
        REG_CAPACITY: capacity <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_OBS:  prdata = PDATA_W'(min_obs);
      REG_CAPACITY: prdata = PDATA_W'(capacity);
      default:      prdata = '0;
    endcase
  end

  pqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cand.valid),
    .in_op    (cand.data.op),
    .in_ready (cand.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pqt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCAN_DEPTH  (SCAN_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (cand.data),
    .min_obs   (min_obs),
    .capacity  (capacity),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (result.data)
  );

endmodule

@@ design/pqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Persistence qualifier table controller
// Sequences candidate lookup, hit update, ranking, table copy and emission.
// ----------------------------------------------------------------------------
module pqt_ctrl import pqt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  pqt_status_t status,
  output pqt_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DUP_RD = 5'd1;
  localparam logic [4:0] S_DUP_EV = 5'd2;
  localparam logic [4:0] S_A_OUT  = 5'd3;
  localparam logic [4:0] S_A_LD   = 5'd4;
  localparam logic [4:0] S_A_RD   = 5'd5;
  localparam logic [4:0] S_A_EV   = 5'd6;
  localparam logic [4:0] S_A_WR   = 5'd7;
  localparam logic [4:0] S_B_OUT  = 5'd8;
  localparam logic [4:0] S_B_LD   = 5'd9;
  localparam logic [4:0] S_B_RD   = 5'd10;
  localparam logic [4:0] S_B_EV   = 5'd11;
  localparam logic [4:0] S_B_WR   = 5'd12;
  localparam logic [4:0] S_C_OUT  = 5'd13;
  localparam logic [4:0] S_C_EV   = 5'd14;
  localparam logic [4:0] S_D_SEL  = 5'd15;
  localparam logic [4:0] S_D_NONE = 5'd16;
  localparam logic [4:0] S_D_OUT  = 5'd17;
  localparam logic [4:0] S_D_EV   = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          if (in_op == OP_END) begin
            cmd.clr_i  = 1'b1;
            state_next = S_A_OUT;
          end else if (status.scan_full) begin
            cmd.drop = 1'b1;
          end else begin
            cmd.clr_j  = 1'b1;
            state_next = S_DUP_RD;
          end
        end
      end
      S_DUP_RD: begin
        cmd.sc_use_j = 1'b1;
        if (status.j_eq_scan) begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DUP_EV;
        end
      end
      S_DUP_EV: begin
        if (status.dup_hit) begin
          cmd.drop   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_DUP_RD;
        end
      end
      S_A_OUT: begin
        if (status.i_eq_scan) begin
          cmd.clr_i  = 1'b1;
          state_next = S_B_OUT;
        end else begin
          cmd.clr_j  = 1'b1;
          state_next = S_A_LD;
        end
      end
      S_A_LD: begin
        cmd.load_cur = 1'b1;
        state_next   = S_A_RD;
      end
      S_A_RD: begin
        state_next = status.j_eq_tr ? S_A_WR : S_A_EV;
      end
      S_A_EV: begin
        if (status.start_match) begin
          cmd.set_h  = status.full_match;
          state_next = S_A_WR;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_A_WR: begin
        cmd.wr_hits = 1'b1;
        cmd.inc_i   = 1'b1;
        state_next  = S_A_OUT;
      end
      S_B_OUT: begin
        if (status.i_eq_scan) begin
          cmd.clr_i    = 1'b1;
          cmd.clr_copy = 1'b1;
          state_next   = S_C_OUT;
        end else begin
          cmd.clr_j     = 1'b1;
          cmd.clr_ahead = 1'b1;
          state_next    = S_B_LD;
        end
      end
      S_B_LD: begin
        cmd.load_rank = 1'b1;
        state_next    = S_B_RD;
      end
      S_B_RD: begin
        cmd.sc_use_j = 1'b1;
        state_next   = status.j_eq_scan ? S_B_WR : S_B_EV;
      end
      S_B_EV: begin
        cmd.rank_step = 1'b1;
        cmd.inc_j     = 1'b1;
        state_next    = S_B_RD;
      end
      S_B_WR: begin
        cmd.wr_keep = 1'b1;
        cmd.inc_i   = 1'b1;
        state_next  = S_B_OUT;
      end
      S_C_OUT: begin
        if (status.i_eq_scan) begin
          cmd.commit_tracked = 1'b1;
          cmd.clr_i          = 1'b1;
          state_next         = S_D_SEL;
        end else begin
          state_next = S_C_EV;
        end
      end
      S_C_EV: begin
        cmd.copy_step = 1'b1;
        cmd.inc_i     = 1'b1;
        state_next    = S_C_OUT;
      end
      S_D_SEL: begin
        cmd.tr_use_i = 1'b1;
        state_next   = status.none_qual ? S_D_NONE : S_D_OUT;
      end
      S_D_NONE: begin
        if (status.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_D_OUT: begin
        cmd.tr_use_i = 1'b1;
        state_next   = status.i_eq_tr ? S_FIN : S_D_EV;
      end
      S_D_EV: begin
        cmd.tr_use_i = 1'b1;
        if (!status.is_qual) begin
          cmd.inc_i  = 1'b1;
          state_next = S_D_OUT;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.inc_i  = 1'b1;
          state_next = S_D_OUT;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/pqt_dp.sv @@
// ----------------------------------------------------------------------------
// Persistence qualifier table datapath
// Scan buffer, tracked table, walk counters and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqt_dp import pqt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SCAN_DEPTH  = SCAN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pqt_cmd_t          cmd,
  output pqt_status_t       status,
  input  pqt_in_t           in_data,
  input  logic [CFG_W-1:0]  min_obs,
  input  logic [CFG_W-1:0]  capacity,
  input  logic              out_ready,
  output logic              out_valid,
  output pqt_out_t          out_data
);

  localparam int SA_W = $clog2(SCAN_DEPTH);
  localparam int TA_W = $clog2(TABLE_DEPTH);
  localparam int MAXD = (SCAN_DEPTH > TABLE_DEPTH) ? SCAN_DEPTH : TABLE_DEPTH;
  localparam int LW   = $clog2(MAXD + 1);

  logic [ADDR_W-1:0] sc_start [SCAN_DEPTH];
  logic [ADDR_W-1:0] sc_end   [SCAN_DEPTH];
  logic [SWAP_W-1:0] sc_swap  [SCAN_DEPTH];
  logic [HITS_W-1:0] sc_hits  [SCAN_DEPTH];
  logic              sc_keep  [SCAN_DEPTH];

  logic [ADDR_W-1:0] tr_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] tr_end   [TABLE_DEPTH];
  logic [SWAP_W-1:0] tr_swap  [TABLE_DEPTH];
  logic [HITS_W-1:0] tr_hits  [TABLE_DEPTH];

  logic [ADDR_W-1:0] sr_start, sr_end, trd_start, trd_end;
  logic [SWAP_W-1:0] sr_swap, trd_swap;
  logic [HITS_W-1:0] sr_hits, trd_hits;
  logic              sr_keep;

  logic [ADDR_W-1:0] in_start, in_end, cur_start, cur_end;
  logic [SWAP_W-1:0] in_swap, cur_swap;
  logic [HITS_W-1:0] cur_h;

  logic [LW-1:0]     i_idx, j_idx, scan_count, tracked_count;
  logic [LW-1:0]     ahead, kept, qual, last_q;
  logic [DROP_W-1:0] scan_dropped;

  logic [SA_W-1:0] sc_ra;
  logic [TA_W-1:0] tr_ra;
  logic [31:0]     cap_eff;
  logic            keep_bit, copy_ok, ahead_hit;
  logic [HITS_W-1:0] min_ext, hits_inc;

  assign sc_ra    = cmd.sc_use_j ? j_idx[SA_W-1:0] : i_idx[SA_W-1:0];
  assign tr_ra    = cmd.tr_use_i ? i_idx[TA_W-1:0] : j_idx[TA_W-1:0];
  assign cap_eff  = (32'(capacity) < 32'(TABLE_DEPTH)) ? 32'(capacity) : 32'(TABLE_DEPTH);
  assign keep_bit = 32'(ahead) < cap_eff;
  assign copy_ok  = sr_keep && (32'(kept) < 32'(TABLE_DEPTH));
  assign min_ext  = {1'b0, min_obs};
  assign hits_inc = (trd_hits == HITS_MAX) ? HITS_MAX : trd_hits + 8'd1;
  assign ahead_hit = (sr_hits > cur_h) || ((sr_hits == cur_h) && (j_idx < i_idx));

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      sc_start[scan_count[SA_W-1:0]] <= in_start;
      sc_end[scan_count[SA_W-1:0]]   <= in_end;
      sc_swap[scan_count[SA_W-1:0]]  <= in_swap;
    end
    if (cmd.wr_hits) begin
      sc_hits[i_idx[SA_W-1:0]] <= cur_h;
    end
    if (cmd.wr_keep) begin
      sc_keep[i_idx[SA_W-1:0]] <= keep_bit;
    end
    sr_start <= sc_start[sc_ra];
    sr_end   <= sc_end[sc_ra];
    sr_swap  <= sc_swap[sc_ra];
    sr_hits  <= sc_hits[sc_ra];
    sr_keep  <= sc_keep[sc_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step && copy_ok) begin
      tr_start[kept[TA_W-1:0]] <= sr_start;
      tr_end[kept[TA_W-1:0]]   <= sr_end;
      tr_swap[kept[TA_W-1:0]]  <= sr_swap;
      tr_hits[kept[TA_W-1:0]]  <= sr_hits;
    end
    trd_start <= tr_start[tr_ra];
    trd_end   <= tr_end[tr_ra];
    trd_swap  <= tr_swap[tr_ra];
    trd_hits  <= tr_hits[tr_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_start <= in_data.region_start;
      in_end   <= in_data.region_end;
      in_swap  <= in_data.swap_kb;
    end
    if (cmd.load_cur) begin
      cur_start <= sr_start;
      cur_end   <= sr_end;
      cur_swap  <= sr_swap;
      cur_h     <= 8'd1;
    end else if (cmd.set_h) begin
      cur_h <= hits_inc;
    end else if (cmd.load_rank) begin
      cur_h <= sr_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx         <= '0;
      j_idx         <= '0;
      scan_count    <= '0;
      scan_dropped  <= '0;
      tracked_count <= '0;
      ahead         <= '0;
      kept          <= '0;
      qual          <= '0;
      last_q        <= '0;
    end else begin
      if (cmd.clr_i) begin
        i_idx <= '0;
      end else if (cmd.inc_i) begin
        i_idx <= i_idx + 1'b1;
      end
      if (cmd.clr_j) begin
        j_idx <= '0;
      end else if (cmd.inc_j) begin
        j_idx <= j_idx + 1'b1;
      end
      if (cmd.finish) begin
        scan_count   <= '0;
        scan_dropped <= '0;
      end else begin
        if (cmd.append) begin
          scan_count <= scan_count + 1'b1;
        end
        if (cmd.drop && (scan_dropped != '1)) begin
          scan_dropped <= scan_dropped + 1'b1;
        end
      end
      if (cmd.commit_tracked) begin
        tracked_count <= kept;
      end
      if (cmd.clr_ahead) begin
        ahead <= '0;
      end else if (cmd.rank_step && ahead_hit) begin
        ahead <= ahead + 1'b1;
      end
      if (cmd.clr_copy) begin
        kept <= '0;
        qual <= '0;
      end else if (cmd.copy_step && copy_ok) begin
        kept <= kept + 1'b1;
        if (sr_hits >= min_ext) begin
          qual   <= qual + 1'b1;
          last_q <= kept;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_none) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_none) begin
      out_data.has_region      <= cmd.emit;
      out_data.stable_start    <= cmd.emit ? trd_start : '0;
      out_data.stable_end      <= cmd.emit ? trd_end : '0;
      out_data.stable_swap_kb  <= cmd.emit ? trd_swap : '0;
      out_data.observations    <= cmd.emit ? trd_hits : '0;
      out_data.candidates_seen <= (32'(scan_count) > 32'd255) ? 8'hFF : SEEN_W'(scan_count);
      out_data.dropped_count   <= scan_dropped;
      out_data.last            <= cmd.emit_none || (i_idx == last_q);
    end
  end

  always_comb begin
    status.scan_full   = 32'(scan_count) >= 32'(SCAN_DEPTH);
    status.i_eq_scan   = i_idx == scan_count;
    status.j_eq_scan   = j_idx == scan_count;
    status.i_eq_tr     = i_idx == tracked_count;
    status.j_eq_tr     = j_idx == tracked_count;
    status.dup_hit     = sr_start == in_start;
    status.start_match = trd_start == cur_start;
    status.full_match  = (trd_end == cur_end) && (trd_swap == cur_swap);
    status.is_qual     = trd_hits >= min_ext;
    status.none_qual   = qual == '0;
    status.out_free    = !out_valid || out_ready;
  end

  `PQT_ASSERT(a_scan_bound, clk, rst, 32'(scan_count) <= 32'(SCAN_DEPTH))
  `PQT_ASSERT(a_table_bound, clk, rst, 32'(tracked_count) <= 32'(TABLE_DEPTH))
  `PQT_ASSERT_IMPL(a_emit_room, clk, rst, cmd.emit || cmd.emit_none, !out_valid || out_ready)
  `PQT_ASSERT_IMPL(a_append_room, clk, rst, cmd.append, !status.scan_full && !cmd.drop)

endmodule
